// File: design/vbgs_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants of the variance-based PID gain scheduler.
// No dependencies; every other file of the block imports this package.
package vbgs_pkg;

  localparam int HISTORY_DEPTH = 10;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int N_W           = $clog2(HISTORY_DEPTH + 1);

  localparam int TEMP_W  = 16;
  localparam int ERR_W   = TEMP_W + 1;
  localparam int MAG_W   = TEMP_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int S1_W    = ERR_W + $clog2(HISTORY_DEPTH);
  localparam int S2_W    = SQ_W + $clog2(HISTORY_DEPTH);
  localparam int NS2_W   = S2_W + N_W;
  localparam int SQ1_W   = 2 * (S1_W - 1);
  localparam int SPR_W   = NS2_W;
  localparam int N2_W    = 2 * N_W;
  localparam int VAR_W   = 24;
  localparam int THR_W   = VAR_W + N2_W;
  localparam int CMP_W   = (SPR_W > THR_W) ? SPR_W : THR_W;

  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int BASE_W    = 16;
  localparam int LIMIT_W   = 16;

  localparam int GAIN_W    = 17;
  localparam int MULT_W    = 4;
  localparam int PROD_W    = BASE_W + MULT_W;
  localparam int DIV_SHIFT = 23;
  localparam logic [PROD_W-1:0] RECIP_TEN = PROD_W'(838861);

  localparam logic [MULT_W-1:0] MULT_OSC_P = MULT_W'(8);
  localparam logic [MULT_W-1:0] MULT_OSC_I = MULT_W'(5);
  localparam logic [MULT_W-1:0] MULT_OSC_D = MULT_W'(12);
  localparam logic [MULT_W-1:0] MULT_STB_P = MULT_W'(12);
  localparam logic [MULT_W-1:0] MULT_STB_I = MULT_W'(8);
  localparam logic [MULT_W-1:0] MULT_STB_D = MULT_W'(8);
  localparam logic [MULT_W-1:0] MULT_UNITY = MULT_W'(10);

  typedef enum logic [1:0] {
    MODE_OSC    = 2'd0,
    MODE_STABLE = 2'd1,
    MODE_BASE   = 2'd2
  } tmode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_KP       = 3'd0,
    CFG_BASE_KI       = 3'd1,
    CFG_BASE_KD       = 3'd2,
    CFG_OUTLIER_LIMIT = 3'd3,
    CFG_VARIANCE_HIGH = 3'd4,
    CFG_VARIANCE_LOW  = 3'd5,
    CFG_NEAR_LIMIT    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [ERR_W-1:0] wr_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
  } ring_req_t;

  typedef struct packed {
    logic   start;
    tmode_t mode;
  } gain_req_t;

  typedef struct packed {
    logic              done;
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
  } gain_rsp_t;

endpackage

// File: design/vbgs_ring.sv
`timescale 1ns / 1ps
// Error history memory: one write port, one registered read port.
// Per-entry valid bits make unwritten entries read as zero. Uses vbgs_pkg.
module vbgs_ring
  import vbgs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  ring_req_t               req,
  output logic signed [ERR_W-1:0] rd_data
);

  logic signed [ERR_W-1:0] mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] valid_r;
  logic signed [ERR_W-1:0] rd_word_r;
  logic                    rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word_r <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_word_r : '0;

endmodule

// File: design/vbgs_gain.sv
`timescale 1ns / 1ps
// Gain scaling unit: base gain times a tenths multiplier, truncated.
// Gains are formed in turn, each scaled and then divided by ten through a reciprocal. Uses vbgs_pkg.
module vbgs_gain
  import vbgs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  gain_req_t         req,
  input  logic [BASE_W-1:0] base_kp,
  input  logic [BASE_W-1:0] base_ki,
  input  logic [BASE_W-1:0] base_kd,
  output gain_rsp_t         rsp
);

  typedef enum logic [1:0] {
    G_IDLE,
    G_SCALE,
    G_DIV
  } gstate_t;

  gstate_t             state_r;
  tmode_t              mode_r;
  logic [1:0]          sel_r;
  logic [PROD_W-1:0]   prod_r;
  logic [GAIN_W-1:0]   gain_p_r;
  logic [GAIN_W-1:0]   gain_i_r;
  logic [GAIN_W-1:0]   gain_d_r;
  logic                done_r;
  logic [BASE_W-1:0]   base_sel;
  logic [MULT_W-1:0]   mult_sel;
  logic [2*PROD_W-1:0] recip_prod;
  logic [GAIN_W-1:0]   quot;

  always_comb begin
    case (sel_r)
      2'd0:    base_sel = base_kp;
      2'd1:    base_sel = base_ki;
      default: base_sel = base_kd;
    endcase
  end

  always_comb begin
    mult_sel = MULT_UNITY;
    case (mode_r)
      MODE_OSC: begin
        case (sel_r)
          2'd0:    mult_sel = MULT_OSC_P;
          2'd1:    mult_sel = MULT_OSC_I;
          default: mult_sel = MULT_OSC_D;
        endcase
      end
      MODE_STABLE: begin
        case (sel_r)
          2'd0:    mult_sel = MULT_STB_P;
          2'd1:    mult_sel = MULT_STB_I;
          default: mult_sel = MULT_STB_D;
        endcase
      end
      default: mult_sel = MULT_UNITY;
    endcase
  end

  assign recip_prod = prod_r * RECIP_TEN;
  assign quot       = recip_prod[DIV_SHIFT+GAIN_W-1:DIV_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= G_IDLE;
      done_r  <= 1'b0;
      sel_r   <= 2'd0;
      mode_r  <= MODE_BASE;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        G_IDLE: begin
          if (req.start) begin
            mode_r  <= req.mode;
            sel_r   <= 2'd0;
            state_r <= G_SCALE;
          end
        end
        G_SCALE: begin
          prod_r  <= base_sel * mult_sel;
          state_r <= G_DIV;
        end
        G_DIV: begin
          case (sel_r)
            2'd0:    gain_p_r <= quot;
            2'd1:    gain_i_r <= quot;
            default: gain_d_r <= quot;
          endcase
          if (sel_r == 2'd2) begin
            done_r  <= 1'b1;
            state_r <= G_IDLE;
          end else begin
            sel_r   <= sel_r + 2'd1;
            state_r <= G_SCALE;
          end
        end
        default: state_r <= G_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.gain_p = gain_p_r;
  assign rsp.gain_i = gain_i_r;
  assign rsp.gain_d = gain_d_r;

endmodule

// File: design/variance_based_pid_gain_scheduler.sv
`timescale 1ns / 1ps
// Top level of the variance-based PID gain scheduler: sequencer, statistics
// and variance test. Uses vbgs_pkg, vbgs_ring and vbgs_gain.
//
// Usage:
//   Input channel in_valid/in_stall carries one adaptation item (setpoint and
//   measured temperature). The error is written into a 10-entry history ring
//   held in a synchronous memory, then the ring is read back one entry per
//   cycle to form count, sum and sum of squares of the non-outlier entries.
//   Output channel out_valid/out_stall carries the new gains and tuning mode.
//   An item with no non-outlier history entry yields no result.
//   From accept to out_valid an item passes the ring reads, the pipeline drain,
//   the variance steps, the shared gain unit and the output register load. One
//   item is in work at a time; an item with no result ends early, and an item
//   takes longer while a result waits. The result sits in an output register:
//   the next item is accepted while it waits, and a new result waits for that
//   register to drain. Configuration writes on cfg_wr_en take effect at once
//   and are to be made by the user while the block is idle; the block itself
//   does not enforce this. Synchronous reset clears the history, the ring
//   pointer and all control state, and loads the register defaults.
module variance_based_pid_gain_scheduler
  import vbgs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [TEMP_W-1:0] in_setpoint_temp,
  input  logic signed [TEMP_W-1:0] in_measured_temp,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [GAIN_W-1:0]        out_gain_p,
  output logic [GAIN_W-1:0]        out_gain_i,
  output logic [GAIN_W-1:0]        out_gain_d,
  output logic [1:0]               out_tuning_mode,
  input  logic                     cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_MUL4,
    ST_DECIDE,
    ST_GAIN
  } state_t;

  state_t state_r;

  logic [BASE_W-1:0]  base_kp_r;
  logic [BASE_W-1:0]  base_ki_r;
  logic [BASE_W-1:0]  base_kd_r;
  logic [LIMIT_W-1:0] outlier_r;
  logic [VAR_W-1:0]   var_high_r;
  logic [VAR_W-1:0]   var_low_r;
  logic [LIMIT_W-1:0] near_limit_r;

  logic [IDX_W-1:0]        pos_r;
  logic [N_W-1:0]          step_r;
  logic                    near_r;
  logic                    rd_vld_r;
  logic                    use_r;
  logic signed [ERR_W-1:0] e_r;
  logic [SQ_W-1:0]         sq_r;
  logic [N_W-1:0]          n_r;
  logic signed [S1_W-1:0]  s1_r;
  logic [S2_W-1:0]         s2_r;
  logic [NS2_W-1:0]        ns2_r;
  logic [N2_W-1:0]         n2_r;
  logic [S1_W-2:0]         s1_mag_r;
  logic [SQ1_W-1:0]        s1sq_r;
  logic [SPR_W-1:0]        spread_r;
  logic [THR_W-1:0]        thr_r;
  logic                    hi_r;
  tmode_t                  mode_r;

  logic                    out_valid_r;
  logic [GAIN_W-1:0]       out_gain_p_r;
  logic [GAIN_W-1:0]       out_gain_i_r;
  logic [GAIN_W-1:0]       out_gain_d_r;
  tmode_t                  out_mode_r;

  logic signed [ERR_W-1:0] err_w;
  logic [ERR_W-1:0]        err_mag;
  logic signed [ERR_W-1:0] rd_data;
  logic [ERR_W-1:0]        rd_mag;
  logic [S1_W-1:0]         s1_abs;
  logic                    in_acc;
  logic                    out_free;
  logic                    lo_w;
  ring_req_t               ring_req;
  gain_req_t               gain_req;
  gain_rsp_t               gain_rsp;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign err_w   = ERR_W'(in_setpoint_temp) - ERR_W'(in_measured_temp);
  assign err_mag = err_w[ERR_W-1] ? -err_w : err_w;
  assign rd_mag  = rd_data[ERR_W-1] ? -rd_data : rd_data;
  assign s1_abs  = s1_r[S1_W-1] ? -s1_r : s1_r;
  assign lo_w    = CMP_W'(spread_r) < CMP_W'(thr_r);

  always_comb begin
    ring_req.wr_en   = in_acc;
    ring_req.wr_addr = pos_r;
    ring_req.wr_data = err_w;
    ring_req.rd_en   = (state_r == ST_WALK);
    ring_req.rd_addr = step_r[IDX_W-1:0];
  end

  vbgs_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ring_req),
    .rd_data (rd_data)
  );

  always_comb begin
    gain_req.start = (state_r == ST_DECIDE) && out_free;
    if (hi_r) begin
      gain_req.mode = MODE_OSC;
    end else if (lo_w && near_r) begin
      gain_req.mode = MODE_STABLE;
    end else begin
      gain_req.mode = MODE_BASE;
    end
  end

  vbgs_gain u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (gain_req),
    .base_kp (base_kp_r),
    .base_ki (base_ki_r),
    .base_kd (base_kd_r),
    .rsp     (gain_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_kp_r    <= BASE_W'(256);
      base_ki_r    <= BASE_W'(256);
      base_kd_r    <= BASE_W'(256);
      outlier_r    <= LIMIT_W'(800);
      var_high_r   <= VAR_W'(1280);
      var_low_r    <= VAR_W'(128);
      near_limit_r <= LIMIT_W'(32);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BASE_KP:       base_kp_r    <= cfg_data[BASE_W-1:0];
        CFG_BASE_KI:       base_ki_r    <= cfg_data[BASE_W-1:0];
        CFG_BASE_KD:       base_kd_r    <= cfg_data[BASE_W-1:0];
        CFG_OUTLIER_LIMIT: outlier_r    <= cfg_data[LIMIT_W-1:0];
        CFG_VARIANCE_HIGH: var_high_r   <= cfg_data[VAR_W-1:0];
        CFG_VARIANCE_LOW:  var_low_r    <= cfg_data[VAR_W-1:0];
        CFG_NEAR_LIMIT:    near_limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // statistics pipeline: read, square and filter, accumulate
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      e_r  <= rd_data;
      sq_r <= rd_mag[MAG_W-1:0] * rd_mag[MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      pos_r    <= '0;
      step_r   <= '0;
      rd_vld_r <= 1'b0;
      use_r    <= 1'b0;
      n_r      <= '0;
      s1_r     <= '0;
      s2_r     <= '0;
      near_r   <= 1'b0;
      hi_r     <= 1'b0;
      mode_r   <= MODE_BASE;
    end else begin
      rd_vld_r <= (state_r == ST_WALK);
      use_r    <= rd_vld_r && (rd_mag < ERR_W'(outlier_r));
      if (use_r) begin
        n_r  <= n_r + N_W'(1);
        s1_r <= s1_r + S1_W'(e_r);
        s2_r <= s2_r + S2_W'(sq_r);
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            near_r  <= err_mag < ERR_W'(near_limit_r);
            pos_r   <= (pos_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : pos_r + IDX_W'(1);
            step_r  <= '0;
            n_r     <= '0;
            s1_r    <= '0;
            s2_r    <= '0;
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (step_r == N_W'(HISTORY_DEPTH - 1)) begin
            state_r <= ST_DRAIN;
          end else begin
            step_r <= step_r + N_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!rd_vld_r && !use_r) begin
            state_r <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          if (n_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            ns2_r    <= n_r * s2_r;
            n2_r     <= n_r * n_r;
            s1_mag_r <= s1_abs[S1_W-2:0];
            state_r  <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          s1sq_r  <= s1_mag_r * s1_mag_r;
          state_r <= ST_MUL3;
        end
        ST_MUL3: begin
          spread_r <= ns2_r - SPR_W'(s1sq_r);
          thr_r    <= var_high_r * n2_r;
          state_r  <= ST_MUL4;
        end
        ST_MUL4: begin
          hi_r    <= CMP_W'(spread_r) > CMP_W'(thr_r);
          thr_r   <= var_low_r * n2_r;
          state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (out_free) begin
            mode_r  <= gain_req.mode;
            state_r <= ST_GAIN;
          end
        end
        ST_GAIN: begin
          if (gain_rsp.done) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (gain_rsp.done) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gain_rsp.done) begin
      out_gain_p_r <= gain_rsp.gain_p;
      out_gain_i_r <= gain_rsp.gain_i;
      out_gain_d_r <= gain_rsp.gain_d;
      out_mode_r   <= mode_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_gain_p      = out_gain_p_r;
  assign out_gain_i      = out_gain_i_r;
  assign out_gain_d      = out_gain_d_r;
  assign out_tuning_mode = out_mode_r;

`ifndef SYNTH
  a_accept_locks: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not stalled after an accepted item");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    gain_rsp.done |-> out_free)
    else $error("new result would overwrite a waiting result");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= IDX_W'(HISTORY_DEPTH - 1))
    else $error("ring pointer out of range");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= N_W'(HISTORY_DEPTH))
    else $error("valid entry count exceeds history depth");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for variance_based_pid_gain_scheduler: directed, register,
// backpressure and random temperature traffic, gains predicted per accepted item.
// Depends on vbgs_pkg and the scheduler RTL only.
module testbench;
  import vbgs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES   = 60;
  localparam int SEGMENTS       = 10;
  localparam int SEGMENT_ITEMS  = 190;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    tmode_t            mode;
  } gain_set_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [TEMP_W-1:0] in_setpoint_temp = '0;
  logic signed [TEMP_W-1:0] in_measured_temp = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [GAIN_W-1:0]        out_gain_p;
  logic [GAIN_W-1:0]        out_gain_i;
  logic [GAIN_W-1:0]        out_gain_d;
  logic [1:0]               out_tuning_mode;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int hold_off_cycles = 0;
  int mismatches      = 0;

  logic [BASE_W-1:0]       kp_base = 16'd256;
  logic [BASE_W-1:0]       ki_base = 16'd256;
  logic [BASE_W-1:0]       kd_base = 16'd256;
  logic [LIMIT_W-1:0]      outlier_lim = 16'd800;
  logic [LIMIT_W-1:0]      near_lim = 16'd32;
  logic [VAR_W-1:0]        var_high = 24'd1280;
  logic [VAR_W-1:0]        var_low = 24'd128;
  logic signed [ERR_W-1:0] err_hist [HISTORY_DEPTH];
  int                      hist_ptr = 0;
  gain_set_t               pending_gains [$];

  variance_based_pid_gain_scheduler DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [GAIN_W-1:0] scale_tenths(input logic [BASE_W-1:0] base,
                                                     input logic [MULT_W-1:0] mult);
    longint prod;
    prod = longint'(base) * longint'(mult) / 10;
    return prod[GAIN_W-1:0];
  endfunction

  function automatic bit schedule_gains(input logic signed [TEMP_W-1:0] setpoint,
                                        input logic signed [TEMP_W-1:0] measured,
                                        output gain_set_t gains);
    longint err, e, mag, s1, s2, cnt, spread, cnt_sq;
    logic [MULT_W-1:0] mp, mi, md;
    int k;
    err = longint'(setpoint) - longint'(measured);
    err_hist[hist_ptr] = ERR_W'(err);
    hist_ptr = (hist_ptr + 1 >= HISTORY_DEPTH) ? 0 : hist_ptr + 1;
    s1 = 0;
    s2 = 0;
    cnt = 0;
    for (k = 0; k < HISTORY_DEPTH; k++) begin
      e = longint'(err_hist[k]);
      mag = (e < 0) ? -e : e;
      if (mag < longint'(outlier_lim)) begin
        s1 += e;
        s2 += e * e;
        cnt++;
      end
    end
    gains = '0;
    if (cnt == 0) return 1'b0;
    spread = cnt * s2 - s1 * s1;
    cnt_sq = cnt * cnt;
    mag = (err < 0) ? -err : err;
    if (spread > longint'(var_high) * cnt_sq) begin
      gains.mode = MODE_OSC;
      mp = MULT_OSC_P;
      mi = MULT_OSC_I;
      md = MULT_OSC_D;
    end else if (spread < longint'(var_low) * cnt_sq && mag < longint'(near_lim)) begin
      gains.mode = MODE_STABLE;
      mp = MULT_STB_P;
      mi = MULT_STB_I;
      md = MULT_STB_D;
    end else begin
      gains.mode = MODE_BASE;
      mp = MULT_UNITY;
      mi = MULT_UNITY;
      md = MULT_UNITY;
    end
    gains.gain_p = scale_tenths(kp_base, mp);
    gains.gain_i = scale_tenths(ki_base, mi);
    gains.gain_d = scale_tenths(kd_base, md);
    return 1'b1;
  endfunction

  always @(posedge clk) begin : predict_accepted
    gain_set_t g;
    if (rst_n && in_valid && !in_stall) begin
      if (schedule_gains(in_setpoint_temp, in_measured_temp, g)) pending_gains.push_back(g);
    end
  end

  always @(posedge clk) begin : check_results
    gain_set_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_gains.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: p=%0d i=%0d d=%0d mode=%0d",
                   out_gain_p, out_gain_i, out_gain_d, out_tuning_mode);
      end else begin
        want = pending_gains.pop_front();
        if (out_gain_p !== want.gain_p || out_gain_i !== want.gain_i ||
            out_gain_d !== want.gain_d || out_tuning_mode !== want.mode) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("gain mismatch: expected p=%0d i=%0d d=%0d mode=%0d, got p=%0d i=%0d d=%0d mode=%0d",
                     want.gain_p, want.gain_i, want.gain_d, want.mode,
                     out_gain_p, out_gain_i, out_gain_d, out_tuning_mode);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall = 1'b1;
      hold_off_cycles--;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_temp(input logic signed [TEMP_W-1:0] setpoint,
                           input logic signed [TEMP_W-1:0] measured);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_setpoint_temp = setpoint;
    in_measured_temp = measured;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Random setpoint, measured value placed so that the error comes out as asked.
  task automatic send_error(input int err);
    int sp, mt;
    sp = int'($urandom_range(0, 65535)) - 32768;
    mt = sp - err;
    if (mt > 32767) sp -= mt - 32767;
    else if (mt < -32768) sp -= mt + 32768;
    mt = sp - err;
    send_temp(TEMP_W'(sp), TEMP_W'(mt));
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_gains.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    case (idx)
      CFG_BASE_KP:       kp_base = value[BASE_W-1:0];
      CFG_BASE_KI:       ki_base = value[BASE_W-1:0];
      CFG_BASE_KD:       kd_base = value[BASE_W-1:0];
      CFG_OUTLIER_LIMIT: outlier_lim = value[LIMIT_W-1:0];
      CFG_VARIANCE_HIGH: var_high = value[VAR_W-1:0];
      CFG_VARIANCE_LOW:  var_low = value[VAR_W-1:0];
      CFG_NEAR_LIMIT:    near_lim = value[LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic load_config(input int kp, input int ki, input int kd, input int outlier,
                             input int v_high, input int v_low, input int near_err);
    write_reg(CFG_BASE_KP, CFG_W'(kp));
    write_reg(CFG_BASE_KI, CFG_W'(ki));
    write_reg(CFG_BASE_KD, CFG_W'(kd));
    write_reg(CFG_OUTLIER_LIMIT, CFG_W'(outlier));
    write_reg(CFG_VARIANCE_HIGH, CFG_W'(v_high));
    write_reg(CFG_VARIANCE_LOW, CFG_W'(v_low));
    write_reg(CFG_NEAR_LIMIT, CFG_W'(near_err));
  endtask

  task automatic test_field_extremes();
    send_temp(16'sd0, 16'sd0);
    send_temp(16'sh7FFF, 16'sh8000);
    send_temp(16'sh8000, 16'sh7FFF);
    send_temp(16'sh7FFF, 16'sh7FFF);
    send_temp(16'sh8000, 16'sh8000);
    send_temp(16'sd31, 16'sd0);
    send_temp(16'sd0, 16'sd32);
    send_temp(16'sd799, 16'sd0);
    send_temp(16'sd0, 16'sd800);
    wait_idle();
  endtask

  task automatic test_mode_selection();
    send_error(400);
    send_error(-400);
    send_error(400);
    send_error(-400);
    wait_idle();
    load_config(65535, 65535, 65535, 65535, 24'hFFFFFF, 24'hFFFFFF, 65535);
    send_temp(16'sh7FFF, -16'sh7FFF);
    send_temp(-16'sh7FFF, 16'sh7FFF);
    send_temp(16'sd0, 16'sd0);
    wait_idle();
    write_reg(CFG_VARIANCE_HIGH, '0);
    send_error(1);
    wait_idle();
  endtask

  task automatic test_register_handling();
    load_config(0, 0, 0, 0, 1280, 0, 0);
    send_error(0);
    send_error(5);
    wait_idle();
    // upper bits of a 16-bit register are dropped, index 7 is ignored
    write_reg(CFG_BASE_KP, 24'hAB1234);
    write_reg(CFG_UNUSED, 24'h000001);
    write_reg(CFG_OUTLIER_LIMIT, 24'hFF0320);
    send_temp(16'sd3, 16'sd0);
    wait_idle();
  endtask

  task automatic test_output_backpressure();
    int k;
    load_config(256, 256, 256, 800, 1280, 128, 32);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 400;
    for (k = 0; k < 24; k++) send_error(int'($urandom_range(0, 200)) - 100);
    wait_idle();
  endtask

  task automatic send_random_items(input int count);
    int sent, kind, len, amp, offset, k;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      len = $urandom_range(4, 14);
      amp = $urandom_range(20, 900);
      offset = int'($urandom_range(0, 60)) - 30;
      for (k = 0; k < len && sent < count; k++) begin
        if (kind < 15) send_temp(TEMP_W'($urandom), TEMP_W'($urandom));
        else if (kind < 50) send_error(offset + int'($urandom_range(0, 6)) - 3);
        else if (kind < 80) send_error((k % 2) ? amp : -amp);
        else send_error(int'($urandom_range(0, 2 * amp)) - amp);
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    int seg;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      if (seg == 0) load_config(256, 256, 256, 800, 1280, 128, 32);
      else load_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                       $urandom_range(0, 65535),
                       ($urandom_range(3) == 0) ? 65535 : $urandom_range(40, 1200),
                       $urandom_range(0, 60000), $urandom_range(0, 3000),
                       $urandom_range(0, 120));
      send_random_items(SEGMENT_ITEMS);
      wait_idle();
    end
  endtask

  initial begin
    int k;
    for (k = 0; k < HISTORY_DEPTH; k++) err_hist[k] = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_field_extremes();
    test_mode_selection();
    test_register_handling();
    test_output_backpressure();
    test_random_traffic();
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
